// ===== rtl/etp_pkg.sv =====
// Package for the exclusive-time profiler bank: widths, opcodes and the per-channel record.
// Depends on nothing; every rtl file imports it.
`timescale 1ns / 1ps
package etp_pkg;

    localparam int TickW  = 16;
    localparam int SumW   = 40;
    localparam int CountW = 24;
    localparam int ChanW  = 4;
    localparam int DefaultChannels = 16;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // One channel's statistics as kept in the statistics memory.
    typedef struct packed {
        logic [TickW-1:0]  least;
        logic [TickW-1:0]  most;
        logic [SumW-1:0]   sum;
        logic [CountW-1:0] stops;
    } stats_t;

    localparam stats_t StatsReset = '{least: '1, most: '0, sum: '0, stops: '0};

endpackage

// ===== rtl/etp_divider.sv =====
// Restoring divider, one quotient bit per cycle: 40-bit total over 24-bit count.
// Depends on etp_pkg.
`timescale 1ns / 1ps
module etp_divider
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [etp_pkg::SumW-1:0]   dividend,
    input  logic [etp_pkg::CountW-1:0] divisor,
    output logic                       done,
    output logic [etp_pkg::TickW-1:0]  quotient
);
    import etp_pkg::*;

    localparam int StepW = $clog2(SumW + 1);

    logic [SumW-1:0]   quo_reg, quo_next;
    logic [CountW-1:0] rem_reg, rem_next;
    logic [CountW-1:0] div_reg;
    logic [StepW-1:0]  step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CountW:0]   trial;

    // The done flag stays high from the last quotient bit until the next start.
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        trial     = {rem_reg, quo_reg[SumW-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            step_next = StepW'(SumW);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so the shifted trial fits CountW+1 bits.
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = CountW'(trial - {1'b0, div_reg});
                quo_next = {quo_reg[SumW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CountW-1:0];
                quo_next = {quo_reg[SumW-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == StepW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = (|quo_reg[SumW-1:TickW]) ? '1 : quo_reg[TickW-1:0];

endmodule

// ===== rtl/exclusive_time_profiler_bank.sv =====
// Top level of the exclusive-time profiler bank: sequencer, channel memories, output register.
// Depends on etp_pkg and etp_divider.
`timescale 1ns / 1ps
// A bank of CHANNELS profiling channels timed by a 16-bit down-counting timer.
// Each input transaction carries an opcode: start records the timestamp and
// marks the channel active; stop on an active channel produces one output
// transaction with the exclusive time (elapsed minus ticks charged to nested
// channels, floored at zero) plus min, max, average and stop count; reset-all
// clears every channel's statistics. Start samples, skip counts and statistics
// sit in synchronous memories, so each transaction is read, modified and
// written back by a sequencer that handles one transaction at a time. A start
// completes in the cycle it is accepted. A stop keeps the input stalled while
// the sequencer reads the channel's memories, calculates the new statistics,
// sweeps the skip counts of every channel (read, then write back to the other
// active channels), waits for the 40-bit average division, which runs
// alongside the sweep, and moves the result to the output register; its output
// transaction appears in the same cycle that the input stall is released.
// Reset-all sweeps the memories, clearing every skip count and statistics
// record. After reset the same clearing sweep runs once, holding the input
// stalled, before the first input transaction is taken. Start and stop on
// channel numbers at or beyond CHANNELS, and the unused opcode, are ignored. An
// output transaction waiting in the output register does not block acceptance
// of the next input transaction; only a second result stalls behind it.
module exclusive_time_profiler_bank
#(
    parameter int CHANNELS = etp_pkg::DefaultChannels
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 opcode,
    input  logic [etp_pkg::ChanW-1:0]  channel,
    input  logic [etp_pkg::TickW-1:0]  timestamp,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [etp_pkg::ChanW-1:0]  channel_out,
    output logic [etp_pkg::TickW-1:0]  exclusive_time,
    output logic [etp_pkg::TickW-1:0]  min_time,
    output logic [etp_pkg::TickW-1:0]  max_time,
    output logic [etp_pkg::TickW-1:0]  average_time,
    output logic [etp_pkg::CountW-1:0] stop_count
);
    import etp_pkg::*;

    localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CntW = $clog2(CHANNELS + 1);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_CALC  = 8'b0000_1000,
        S_SWEEP = 8'b0001_0000,
        S_SKIP  = 8'b0010_0000,
        S_WAIT  = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } state_t;

    // Channel memories. Activity bits are flip-flops: the sweep needs them all.
    logic [TickW-1:0] start_mem [CHANNELS];
    logic [TickW-1:0] skip_mem  [CHANNELS];
    stats_t           stats_mem [CHANNELS];
    logic [CHANNELS-1:0] active_reg, active_next;

    state_t            state_reg, state_next;
    logic [CntW-1:0]   idx_reg, idx_next;
    logic [IdxW-1:0]   ch_reg;
    logic [TickW-1:0]  stamp_reg;

    logic [TickW-1:0]  start_rd_reg, skip_rd_reg;
    stats_t            stats_rd_reg;
    logic [TickW-1:0]  excl_reg;
    stats_t            stats_new_reg;

    logic              out_valid_reg;
    logic [ChanW-1:0]  out_ch_reg;
    logic [TickW-1:0]  out_excl_reg, out_min_reg, out_max_reg, out_avg_reg;
    logic [CountW-1:0] out_cnt_reg;

    logic              in_take;
    logic              ch_ok;
    logic [IdxW-1:0]   chan_idx;
    logic [IdxW-1:0]   idx_addr;
    logic              div_start, div_done;
    logic [TickW-1:0]  div_q;

    // Combinational results of the stop calculation.
    logic [TickW-1:0]  elapsed;
    logic [TickW-1:0]  excl_c;
    logic [SumW:0]     sum_wide;
    stats_t            stats_c;
    logic [TickW:0]    skip_sum;

    assign idx_addr = idx_reg[IdxW-1:0];
    assign chan_idx = IdxW'(channel);
    assign ch_ok    = ({{(32-ChanW){1'b0}}, channel} < 32'(CHANNELS));
    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        elapsed  = start_rd_reg - stamp_reg;
        excl_c   = (elapsed > skip_rd_reg) ? elapsed - skip_rd_reg : '0;
        stats_c  = stats_rd_reg;
        if (stats_rd_reg.stops != '1)
        begin
            stats_c.stops = stats_rd_reg.stops + 1'b1;
        end
        if (excl_c < stats_rd_reg.least)
        begin
            stats_c.least = excl_c;
        end
        if (excl_c > stats_rd_reg.most)
        begin
            stats_c.most = excl_c;
        end
        sum_wide = {1'b0, stats_rd_reg.sum} + {{(SumW+1-TickW){1'b0}}, excl_c};
        stats_c.sum = sum_wide[SumW] ? '1 : sum_wide[SumW-1:0];
        skip_sum = {1'b0, skip_rd_reg} + {1'b0, excl_reg};
    end

    assign div_start = (state_reg == S_CALC);

    etp_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (stats_c.sum),
        .divisor  (stats_c.stops),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        active_next = active_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == CntW'(CHANNELS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_take)
                begin
                    priority if (opcode == OP_CLEAR)
                    begin
                        active_next = '0;
                        idx_next    = '0;
                        state_next  = S_CLEAR;
                    end
                    else if (opcode == OP_START && ch_ok)
                    begin
                        active_next[chan_idx] = 1'b1;
                    end
                    else if (opcode == OP_STOP && ch_ok && active_reg[chan_idx])
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_CALC;
            end
            S_CALC:
            begin
                active_next[ch_reg] = 1'b0;
                idx_next   = '0;
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                // Issue the read of one channel's skip count.
                state_next = S_SKIP;
            end
            S_SKIP:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == CntW'(CHANNELS - 1))
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    state_next = S_SWEEP;
                end
            end
            S_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            active_reg <= active_next;
            if (state_reg == S_EMIT && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Transaction capture and memory accesses.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ch_reg       <= chan_idx;
            stamp_reg    <= timestamp;
            if (opcode == OP_START && ch_ok)
            begin
                start_mem[chan_idx] <= timestamp;
            end
        end
        unique case (state_reg)
            S_CLEAR:
            begin
                skip_mem[idx_addr]  <= '0;
                stats_mem[idx_addr] <= StatsReset;
            end
            S_READ:
            begin
                start_rd_reg <= start_mem[ch_reg];
                skip_rd_reg  <= skip_mem[ch_reg];
                stats_rd_reg <= stats_mem[ch_reg];
            end
            S_CALC:
            begin
                excl_reg           <= excl_c;
                stats_new_reg      <= stats_c;
                stats_mem[ch_reg]  <= stats_c;
                skip_mem[ch_reg]   <= '0;
            end
            S_SWEEP:
            begin
                skip_rd_reg <= skip_mem[idx_addr];
            end
            S_SKIP:
            begin
                if (active_reg[idx_addr])
                begin
                    skip_mem[idx_addr] <= skip_sum[TickW] ? '1 : skip_sum[TickW-1:0];
                end
            end
            default:
            begin
            end
        endcase
        if (state_reg == S_EMIT && (!out_valid_reg || !out_stall))
        begin
            out_ch_reg   <= ChanW'(ch_reg);
            out_excl_reg <= excl_reg;
            out_min_reg  <= stats_new_reg.least;
            out_max_reg  <= stats_new_reg.most;
            out_avg_reg  <= div_q;
            out_cnt_reg  <= stats_new_reg.stops;
        end
    end

    assign out_valid      = out_valid_reg;
    assign channel_out    = out_ch_reg;
    assign exclusive_time = out_excl_reg;
    assign min_time       = out_min_reg;
    assign max_time       = out_max_reg;
    assign average_time   = out_avg_reg;
    assign stop_count     = out_cnt_reg;

endmodule

// ===== sim/tb_exclusive_time_profiler_bank.sv =====
// Self-checking testbench for the exclusive-time profiler bank.
// Depends on etp_pkg and the exclusive_time_profiler_bank RTL.
`timescale 1ns / 1ps
module tb_exclusive_time_profiler_bank;
    import etp_pkg::*;

    // Input and output transactions as the testbench stores them.
    typedef struct packed {
        op_t               op;
        logic [ChanW-1:0]  chan;
        logic [TickW-1:0]  stamp;
    } cmd_t;

    typedef struct packed {
        logic [ChanW-1:0]  chan;
        logic [TickW-1:0]  excl;
        logic [TickW-1:0]  lo;
        logic [TickW-1:0]  hi;
        logic [TickW-1:0]  avg;
        logic [CountW-1:0] count;
    } timing_t;

    localparam int NCHAN = DefaultChannels;
    localparam int LIMIT_CYCLES = 1000000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] opcode;
    logic [ChanW-1:0] channel;
    logic [TickW-1:0] timestamp;
    logic out_valid;
    logic out_stall;
    logic [ChanW-1:0] channel_out;
    logic [TickW-1:0] exclusive_time;
    logic [TickW-1:0] min_time;
    logic [TickW-1:0] max_time;
    logic [TickW-1:0] average_time;
    logic [CountW-1:0] stop_count;

    exclusive_time_profiler_bank dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .channel(channel), .timestamp(timestamp),
        .out_valid(out_valid), .out_stall(out_stall),
        .channel_out(channel_out), .exclusive_time(exclusive_time),
        .min_time(min_time), .max_time(max_time),
        .average_time(average_time), .stop_count(stop_count)
    );

    // Shadow copy of the channel state, updated as each transaction is accepted.
    logic [TickW-1:0]  shadow_start [NCHAN];
    logic              shadow_active [NCHAN];
    logic [TickW-1:0]  shadow_skip [NCHAN];
    logic [TickW-1:0]  shadow_least [NCHAN];
    logic [TickW-1:0]  shadow_most [NCHAN];
    logic [SumW-1:0]   shadow_sum [NCHAN];
    logic [CountW-1:0] shadow_stops [NCHAN];

    cmd_t    pending_cmds[$];
    timing_t expected_timings[$];
    int      error_count = 0;
    int      cycle_count = 0;
    // Input idling and output stalls are switched off for a long stretch in the middle of the run.
    bit      calm_stretch = 0;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
        error_count++;
    endtask

    function automatic void clear_all_channels();
        for (int k = 0; k < NCHAN; k++)
        begin
            shadow_active[k] = 1'b0;
            shadow_skip[k] = '0;
            shadow_least[k] = '1;
            shadow_most[k] = '0;
            shadow_sum[k] = '0;
            shadow_stops[k] = '0;
        end
    endfunction

    // Applies one accepted command to the shadow state and queues any timing result.
    function automatic void predict_timing(input cmd_t c);
        logic [TickW-1:0] elapsed;
        logic [TickW-1:0] excl;
        logic [SumW:0]    wide_sum;
        logic [SumW-1:0]  quotient;
        logic [16:0]      skip_sum;
        timing_t t;
        int ch;
        ch = c.chan;
        if (c.op == OP_CLEAR)
        begin
            clear_all_channels();
            return;
        end
        if (c.op == OP_NONE || ch >= NCHAN)
            return;
        if (c.op == OP_START)
        begin
            shadow_start[ch] = c.stamp;
            shadow_active[ch] = 1'b1;
            return;
        end
        if (!shadow_active[ch])
            return;
        if (shadow_stops[ch] != '1)
            shadow_stops[ch] = shadow_stops[ch] + 1'b1;
        shadow_active[ch] = 1'b0;
        elapsed = shadow_start[ch] - c.stamp;
        excl = (elapsed > shadow_skip[ch]) ? elapsed - shadow_skip[ch] : '0;
        shadow_skip[ch] = '0;
        if (excl < shadow_least[ch])
            shadow_least[ch] = excl;
        if (excl > shadow_most[ch])
            shadow_most[ch] = excl;
        wide_sum = {1'b0, shadow_sum[ch]} + excl;
        shadow_sum[ch] = wide_sum[SumW] ? '1 : wide_sum[SumW-1:0];
        quotient = shadow_sum[ch] / shadow_stops[ch];
        for (int k = 0; k < NCHAN; k++)
        begin
            if (shadow_active[k])
            begin
                skip_sum = {1'b0, shadow_skip[k]} + excl;
                shadow_skip[k] = skip_sum[16] ? '1 : skip_sum[TickW-1:0];
            end
        end
        t.chan = c.chan;
        t.excl = excl;
        t.lo = shadow_least[ch];
        t.hi = shadow_most[ch];
        t.avg = (quotient > 40'hFFFF) ? 16'hFFFF : quotient[TickW-1:0];
        t.count = shadow_stops[ch];
        expected_timings.push_back(t);
    endfunction

    function automatic cmd_t make_cmd(input op_t op, input int ch, input int stamp);
        cmd_t c;
        c.op = op;
        c.chan = ch[ChanW-1:0];
        c.stamp = stamp[TickW-1:0];
        return c;
    endfunction

    // Random nested start/stop sequence over a few channels with random content.
    task automatic queue_nested_burst();
        int depth;
        int chans[$];
        int now;
        int pick;
        depth = $urandom_range(1, 5);
        now = $urandom_range(0, 65535);
        for (int d = 0; d < depth; d++)
        begin
            pick = $urandom_range(0, NCHAN - 1);
            chans.push_back(pick);
            pending_cmds.push_back(make_cmd(OP_START, pick, now));
            now = (now - $urandom_range(0, 3000)) & 16'hFFFF;
        end
        while (chans.size() > 0)
        begin
            now = (now - $urandom_range(0, 3000)) & 16'hFFFF;
            pending_cmds.push_back(make_cmd(OP_STOP, chans.pop_back(), now));
        end
    endtask

    // Input driver: presents queued commands, idling now and then.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            opcode <= OP_START;
            channel <= '0;
            timestamp <= '0;
        end
        else
        begin
            if (!in_valid || !in_stall)
            begin
                if (pending_cmds.size() > 0 && (calm_stretch || $urandom_range(0, 99) >= 13))
                begin
                    in_valid <= 1'b1;
                    opcode <= pending_cmds[0].op;
                    channel <= pending_cmds[0].chan;
                    timestamp <= pending_cmds[0].stamp;
                    pending_cmds.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: predicts on accepted inputs and checks accepted outputs.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            cycle_count <= cycle_count + 1;
            out_stall <= !calm_stretch && ($urandom_range(0, 99) < 13);
            if (in_valid && !in_stall)
                predict_timing(make_cmd(op_t'(opcode), channel, timestamp));
            if (out_valid && !out_stall)
            begin
                if (expected_timings.size() == 0)
                begin
                    report_mismatch("unexpected result, channel_out", channel_out, -1);
                end
                else
                begin
                    timing_t w;
                    w = expected_timings.pop_front();
                    if (channel_out !== w.chan)
                        report_mismatch("channel_out", channel_out, w.chan);
                    if (exclusive_time !== w.excl)
                        report_mismatch("exclusive_time", exclusive_time, w.excl);
                    if (min_time !== w.lo)
                        report_mismatch("min_time", min_time, w.lo);
                    if (max_time !== w.hi)
                        report_mismatch("max_time", max_time, w.hi);
                    if (average_time !== w.avg)
                        report_mismatch("average_time", average_time, w.avg);
                    if (stop_count !== w.count)
                        report_mismatch("stop_count", stop_count, w.count);
                end
            end
        end
    end

    // Watchdog for a hung block.
    always @(posedge clk)
    begin
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int r;
        clear_all_channels();
        for (int k = 0; k < NCHAN; k++)
            shadow_start[k] = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: extremes, every opcode, and the special cases.
        pending_cmds.push_back(make_cmd(OP_STOP, 3, 100));       // stop while inactive
        pending_cmds.push_back(make_cmd(OP_START, 0, 0));
        pending_cmds.push_back(make_cmd(OP_STOP, 0, 0));         // equal samples
        pending_cmds.push_back(make_cmd(OP_START, 15, 16'hFFFF));
        pending_cmds.push_back(make_cmd(OP_STOP, 15, 0));        // largest elapsed
        pending_cmds.push_back(make_cmd(OP_START, 1, 5));
        pending_cmds.push_back(make_cmd(OP_STOP, 1, 16'hFFF0));  // timer wrap
        pending_cmds.push_back(make_cmd(OP_START, 2, 1000));
        pending_cmds.push_back(make_cmd(OP_START, 2, 900));      // restart while active
        pending_cmds.push_back(make_cmd(OP_START, 4, 800));      // nested channel
        pending_cmds.push_back(make_cmd(OP_STOP, 4, 300));
        pending_cmds.push_back(make_cmd(OP_STOP, 2, 250));       // nested skip subtracted
        pending_cmds.push_back(make_cmd(OP_NONE, 5, 1234));      // unused opcode
        pending_cmds.push_back(make_cmd(OP_START, 6, 16'hAAAA));
        pending_cmds.push_back(make_cmd(OP_CLEAR, 9, 16'h5555)); // clears activity
        pending_cmds.push_back(make_cmd(OP_STOP, 6, 0));
        pending_cmds.push_back(make_cmd(OP_START, 7, 16'hFFFF));
        pending_cmds.push_back(make_cmd(OP_START, 8, 16'hFFFF));
        pending_cmds.push_back(make_cmd(OP_STOP, 8, 0));         // charges a full-scale skip to channel 7
        pending_cmds.push_back(make_cmd(OP_START, 9, 16'hFFFF));
        pending_cmds.push_back(make_cmd(OP_STOP, 9, 0));
        pending_cmds.push_back(make_cmd(OP_STOP, 7, 0));

        // Random part: mostly nested bursts, plus noise commands of any encoding.
        while (pending_cmds.size() < 1200)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
                queue_nested_burst();
            else if (r < 77)
                pending_cmds.push_back(make_cmd(OP_CLEAR, $urandom_range(0, 15),
                                                $urandom_range(0, 65535)));
            else
                pending_cmds.push_back(make_cmd(op_t'($urandom_range(0, 3)),
                                                $urandom_range(0, 15), $urandom_range(0, 65535)));
        end

        wait (pending_cmds.size() < 800);
        calm_stretch = 1'b1;
        wait (pending_cmds.size() < 500);
        calm_stretch = 1'b0;
        wait (pending_cmds.size() == 0);
        @(posedge clk);
        while (in_valid && in_stall)
            @(posedge clk);
        wait (expected_timings.size() == 0);
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
